// File: rtl/core/pbct_pkg.sv
// pbct_pkg: shared types and codes for the pump burst cycle timer
// no dependencies; imported by pbct_engine, pump_burst_cycle_timer_top and the testbench

package pbct_pkg;

    localparam int CYC_W   = 8;
    localparam int TIME_W  = 20;
    localparam int PHASE_W = 21;
    localparam int LEFT_W  = 29;
    localparam int CNUM_W  = 9;
    localparam int LEVEL_W = 7;
    localparam int MODE_W  = 4;
    localparam int IDX_W   = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CYCLE_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_ON_TIME     = 2'd1;
    localparam logic [IDX_W-1:0] REG_OFF_TIME    = 2'd2;

    localparam logic [CYC_W-1:0]  CYCLE_COUNT_RST = 8'd5;
    localparam logic [TIME_W-1:0] ON_TIME_RST     = 20'd10000;
    localparam logic [TIME_W-1:0] OFF_TIME_RST    = 20'd50000;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // result status
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAN = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 7'd100;
    localparam logic [CYC_W-1:0]   CYCLE_MAX  = 8'd255;

    typedef struct packed {
        logic [1:0]        kind;
        logic [MODE_W-1:0] return_mode;
        logic              low_water;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [MODE_W-1:0]  resume_mode;
        logic               relay_on;
        logic [LEVEL_W-1:0] pump_level;
        logic [LEFT_W-1:0]  time_left_ms;
        logic [CNUM_W-1:0]  cycle_number;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] data;
    } t_cfg_wr;

endpackage

// File: rtl/core/pbct_engine.sv
// pbct_engine: configuration registers, burst state and per-beat result logic
// depends on pbct_pkg

module pbct_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pbct_pkg::t_cfg_wr i_cfg,
    input  logic           i_fire,
    input  pbct_pkg::t_in  i_item,
    output pbct_pkg::t_out o_result
);
    import pbct_pkg::*;

    logic [CYC_W-1:0]   r_cyc_cnt;
    logic [TIME_W-1:0]  r_on_time;
    logic [TIME_W-1:0]  r_off_time;

    logic               r_running, n_running;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CYC_W-1:0]   r_cycle, n_cycle;
    logic               r_relay, n_relay;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [MODE_W-1:0]  r_mode, n_mode;

    logic [PHASE_W-1:0] period;
    logic [PHASE_W-1:0] phase_inc;
    logic [LEFT_W-1:0]  total;
    logic [1:0]         status;
    logic               do_eval;
    logic               on_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cyc_cnt  <= CYCLE_COUNT_RST;
            r_on_time  <= ON_TIME_RST;
            r_off_time <= OFF_TIME_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                REG_CYCLE_COUNT: r_cyc_cnt  <= i_cfg.data[CYC_W-1:0];
                REG_ON_TIME:     r_on_time  <= i_cfg.data;
                REG_OFF_TIME:    r_off_time <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign period    = {1'b0, r_on_time} + {1'b0, r_off_time};
    assign phase_inc = r_phase + PHASE_W'(1);
    // burst length latched at start
    assign total     = {{(LEFT_W-CYC_W){1'b0}}, r_cyc_cnt}
                     * {{(LEFT_W-PHASE_W){1'b0}}, period};

    always_comb begin
        n_running = r_running;
        n_left    = r_left;
        n_phase   = r_phase;
        n_cycle   = r_cycle;
        n_relay   = r_relay;
        n_level   = r_level;
        n_mode    = r_mode;
        status    = r_running ? ST_CLEAN : ST_IDLE;
        do_eval   = 1'b0;

        unique case (i_item.kind)
            KIND_START: begin
                n_running = 1'b1;
                n_mode    = i_item.return_mode;
                n_left    = total;
                n_phase   = '0;
                n_cycle   = '0;
                status    = ST_CLEAN;
                do_eval   = 1'b1;
            end
            KIND_STOP: begin
                n_running = 1'b0;
                n_relay   = 1'b0;
                status    = ST_IDLE;
            end
            KIND_TICK: begin
                if (r_running) begin
                    // remaining time already zero: this tick runs past the end
                    if (r_left == '0) begin
                        n_running = 1'b0;
                        n_relay   = 1'b0;
                        status    = ST_DONE;
                    end else begin
                        n_left  = r_left - LEFT_W'(1);
                        do_eval = 1'b1;
                        if (period != '0) begin
                            if (phase_inc >= period) begin
                                n_phase = '0;
                                if (r_cycle < CYCLE_MAX) begin
                                    n_cycle = r_cycle + CYC_W'(1);
                                end
                            end else begin
                                n_phase = phase_inc;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase

        on_phase = (period == '0) || (n_phase < {1'b0, r_on_time});
        if (do_eval) begin
            if (on_phase) begin
                if (!r_relay) begin
                    n_relay = !i_item.low_water;
                    n_level = FULL_LEVEL;
                end
            end else if (r_relay) begin
                n_relay = 1'b0;
                n_level = '0;
            end
        end
    end

    always_comb begin
        o_result.status       = status;
        o_result.resume_mode  = (status == ST_DONE) ? r_mode : '0;
        o_result.relay_on     = n_relay;
        o_result.pump_level   = n_level;
        o_result.time_left_ms = n_running ? n_left : '0;
        o_result.cycle_number = n_running ? ({1'b0, n_cycle} + CNUM_W'(1)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_left    <= '0;
            r_phase   <= '0;
            r_cycle   <= '0;
            r_relay   <= 1'b0;
            r_level   <= '0;
            r_mode    <= '0;
        end else if (i_fire) begin
            r_running <= n_running;
            r_left    <= n_left;
            r_phase   <= n_phase;
            r_cycle   <= n_cycle;
            r_relay   <= n_relay;
            r_level   <= n_level;
            r_mode    <= n_mode;
        end
    end

    // relay is only energised together with full pump level
    a_relay_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_relay |-> (r_level == FULL_LEVEL))
        else $error("relay on without full pump level");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.kind == KIND_START) |=> r_running)
        else $error("start beat did not begin a burst");

    a_stop_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.kind == KIND_STOP) |=> (!r_running && !r_relay))
        else $error("stop beat left burst or relay active");

    a_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.status == ST_DONE) |->
            (o_result.time_left_ms == '0 && o_result.cycle_number == '0
             && !o_result.relay_on))
        else $error("finish result carries burst fields");

endmodule

// File: rtl/core/pump_burst_cycle_timer_top.sv
// pump_burst_cycle_timer_top: handshake stages around the burst engine
// depends on pbct_pkg and pbct_engine
//
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_ready   i_in_data  (t_in)
//  out       source     o_out_valid / i_out_ready o_out_data (t_out)
//  cfg       sink       i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  one beat per cycle sustained while the output is not stalled; a result beat is taken into
//  the input register, computed combinationally by the engine and offered from the output register
//  i_rst_n is synchronous: config returns to 5 / 10000 / 50000, burst inactive
//  a stalled output holds its beat; the input register still takes one more beat

module pump_burst_cycle_timer_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  pbct_pkg::t_in            i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output pbct_pkg::t_out           o_out_data,
    input  logic                     i_cfg_we,
    input  logic [pbct_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [pbct_pkg::TIME_W-1:0] i_cfg_data
);
    import pbct_pkg::*;

    logic    r_in_valid;
    t_in     r_in_data;
    logic    r_out_valid;
    t_out    r_out_data;
    logic    advance;
    t_out    result;
    t_cfg_wr cfg;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    pbct_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (advance),
        .i_item   (r_in_data),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: tb/sv/testbench.sv
// testbench: self-checking bench for pump_burst_cycle_timer_top
// depends on pbct_pkg and the rtl; sends item beats and config writes, and checks every
// result beat against an in-bench model of the burst, phase and cycle counters

module testbench;
    import pbct_pkg::*;

    localparam logic [1:0]  KIND_UNUSED    = 2'd3;
    localparam int unsigned TIME_MAX       = (1 << TIME_W) - 1;
    localparam int unsigned ELAPSED_MAX    = (1 << LEFT_W) - 1;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_GAP      = 6;
    localparam int          ERR_SHOWN      = 10;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in               in_data  = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out              out_data;
    logic              cfg_we   = 1'b0;
    logic [IDX_W-1:0]  cfg_idx  = '0;
    logic [TIME_W-1:0] cfg_data = '0;

    always #5 clk = ~clk;

    pump_burst_cycle_timer_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // mirror of the burst state and the registers
    int unsigned        cyc_cfg, on_cfg, off_cfg;
    bit                 run_q;
    bit                 relay_q;
    int unsigned        elapsed_q, phase_q, cycle_q, total_q;
    logic [LEVEL_W-1:0] level_q;
    logic [MODE_W-1:0]  mode_q;

    t_out burst_reports[$];
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   errors = 0;
    int   items_sent = 0;
    int   reports_checked = 0;
    int   finishes_seen = 0;
    int   max_cycle_seen = 0;
    int   quiet_cycles = 0;

    function automatic void reset_mirror();
        cyc_cfg   = 32'(CYCLE_COUNT_RST);
        on_cfg    = 32'(ON_TIME_RST);
        off_cfg   = 32'(OFF_TIME_RST);
        run_q     = 1'b0;
        relay_q   = 1'b0;
        elapsed_q = 0;
        phase_q   = 0;
        cycle_q   = 0;
        total_q   = 0;
        level_q   = '0;
        mode_q    = '0;
    endfunction

    // end check plus relay/level update for the current phase position
    function automatic logic [1:0] settle_phase(input bit low);
        int unsigned period;
        period = on_cfg + off_cfg;
        if (elapsed_q > total_q) begin
            run_q   = 1'b0;
            relay_q = 1'b0;
            return ST_DONE;
        end
        if (period == 0 || phase_q < on_cfg) begin
            // on phase only acts while the relay is open
            if (!relay_q) begin
                relay_q = !low;
                level_q = FULL_LEVEL;
            end
        end else if (relay_q) begin
            relay_q = 1'b0;
            level_q = '0;
        end
        return ST_CLEAN;
    endfunction

    function automatic t_out advance_burst(input t_in item);
        t_out        r;
        logic [1:0]  st;
        int unsigned period;
        st     = run_q ? ST_CLEAN : ST_IDLE;
        period = on_cfg + off_cfg;
        case (item.kind)
            KIND_START: begin
                run_q     = 1'b1;
                mode_q    = item.return_mode;
                total_q   = cyc_cfg * period;
                elapsed_q = 0;
                phase_q   = 0;
                cycle_q   = 0;
                st        = settle_phase(item.low_water);
            end
            KIND_STOP: begin
                run_q   = 1'b0;
                relay_q = 1'b0;
                st      = ST_IDLE;
            end
            KIND_TICK: begin
                if (run_q) begin
                    if (elapsed_q < ELAPSED_MAX)
                        elapsed_q++;
                    if (period != 0) begin
                        phase_q++;
                        if (phase_q >= period) begin
                            phase_q = 0;
                            if (cycle_q < CYCLE_MAX)
                                cycle_q++;
                        end
                    end
                    st = settle_phase(item.low_water);
                end
            end
            default: ;
        endcase
        r.status       = st;
        r.resume_mode  = (st == ST_DONE) ? mode_q : '0;
        r.relay_on     = relay_q;
        r.pump_level   = level_q;
        r.time_left_ms = (run_q && total_q >= elapsed_q) ? LEFT_W'(total_q - elapsed_q) : '0;
        r.cycle_number = run_q ? CNUM_W'(cycle_q + 1) : '0;
        return r;
    endfunction

    task automatic check_report(input t_out got);
        t_out want;
        if (burst_reports.size() == 0) begin
            errors++;
            if (errors <= ERR_SHOWN)
                $display("unexpected result beat: status %0d cycle %0d", got.status,
                         got.cycle_number);
        end else begin
            want = burst_reports.pop_front();
            reports_checked++;
            if (got.status == ST_DONE)
                finishes_seen++;
            if (got.cycle_number > max_cycle_seen)
                max_cycle_seen = int'(got.cycle_number);
            if (got.status !== want.status || got.resume_mode !== want.resume_mode ||
                got.relay_on !== want.relay_on || got.pump_level !== want.pump_level ||
                got.time_left_ms !== want.time_left_ms ||
                got.cycle_number !== want.cycle_number) begin
                errors++;
                if (errors <= ERR_SHOWN)
                    $display({"result %0d mismatch: ",
                              "exp st %0d md %0d rl %0d lv %0d left %0d cyc %0d, ",
                              "got st %0d md %0d rl %0d lv %0d left %0d cyc %0d"},
                             reports_checked, want.status, want.resume_mode, want.relay_on,
                             want.pump_level, want.time_left_ms, want.cycle_number,
                             got.status, got.resume_mode, got.relay_on, got.pump_level,
                             got.time_left_ms, got.cycle_number);
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            check_report(out_data);
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // nothing accepted on either side for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, burst_reports.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(input t_in item);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_reports.push_back(advance_burst(item));
        items_sent++;
    endtask

    task automatic send_beat(input logic [1:0] kind, input logic [MODE_W-1:0] mode,
                             input logic low);
        t_in item;
        item.kind        = kind;
        item.return_mode = mode;
        item.low_water   = low;
        send_item(item);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (burst_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic load_config(input int unsigned cyc, input int unsigned on_t,
                               input int unsigned off_t);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_CYCLE_COUNT;
        cfg_data <= TIME_W'(cyc);
        @(posedge clk);
        cyc_cfg = cyc & 8'hFF;
        cfg_idx  <= REG_ON_TIME;
        cfg_data <= TIME_W'(on_t);
        @(posedge clk);
        on_cfg = on_t & TIME_MAX;
        cfg_idx  <= REG_OFF_TIME;
        cfg_data <= TIME_W'(off_t);
        @(posedge clk);
        off_cfg = off_t & TIME_MAX;
        cfg_we <= 1'b0;
    endtask

    function automatic int unsigned pick_time();
        int unsigned sel;
        sel = $urandom_range(19);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return TIME_MAX;
        if (sel == 2)
            return $urandom_range(TIME_MAX);
        return $urandom_range(4);
    endfunction

    function automatic int unsigned pick_count();
        int unsigned sel;
        sel = $urandom_range(15);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return 32'(CYCLE_MAX);
        return $urandom_range(6);
    endfunction

    // mostly starts when idle and ticks while running, with some noise
    function automatic t_in pick_beat();
        t_in         item;
        int unsigned roll;
        roll             = $urandom_range(99);
        item.return_mode = MODE_W'($urandom_range(15));
        item.low_water   = ($urandom_range(3) == 0);
        if (!run_q)
            item.kind = (roll < 60) ? KIND_START : (roll < 75) ? KIND_TICK :
                        (roll < 90) ? KIND_STOP : KIND_UNUSED;
        else
            item.kind = (roll < 86) ? KIND_TICK : (roll < 90) ? KIND_START :
                        (roll < 95) ? KIND_STOP : KIND_UNUSED;
        return item;
    endfunction

    task automatic test_idle_kinds();
        idle_pct  = 0;
        stall_pct = 0;
        send_beat(KIND_TICK, 4'h0, 1'b0);
        send_beat(KIND_STOP, 4'hA, 1'b1);
        send_beat(KIND_UNUSED, 4'h5, 1'b0);
        // low water at start: level to full, relay held open
        send_beat(KIND_START, 4'hF, 1'b1);
        send_beat(KIND_TICK, 4'h0, 1'b0);
        send_beat(KIND_UNUSED, 4'h3, 1'b1);
        send_beat(KIND_STOP, 4'h0, 1'b0);
    endtask

    task automatic test_field_extremes();
        load_config(32'(CYCLE_MAX), TIME_MAX, TIME_MAX);
        send_beat(KIND_START, 4'h0, 1'b0);
        send_beat(KIND_TICK, 4'h0, 1'b1);
        // restart while running
        send_beat(KIND_START, 4'hF, 1'b0);
        send_beat(KIND_STOP, 4'h0, 1'b1);
    endtask

    task automatic test_short_burst();
        load_config(1, 2, 1);
        send_beat(KIND_START, 4'h9, 1'b1);
        send_beat(KIND_TICK, 4'h0, 1'b1);
        // off phase with the relay open keeps the full level
        send_beat(KIND_TICK, 4'h0, 1'b0);
        send_beat(KIND_TICK, 4'h0, 1'b0);
        send_beat(KIND_TICK, 4'h0, 1'b0);
        send_beat(KIND_TICK, 4'h0, 1'b0);
    endtask

    task automatic test_zero_totals();
        load_config(0, 3, 2);
        send_beat(KIND_START, 4'h6, 1'b0);
        send_beat(KIND_TICK, 4'h0, 1'b0);
        // zero period: stays in the on phase
        load_config(3, 0, 0);
        send_beat(KIND_START, 4'hC, 1'b0);
        send_beat(KIND_TICK, 4'h0, 1'b1);
    endtask

    task automatic test_cycle_saturation();
        idle_pct  = 28;
        stall_pct = 28;
        load_config(32'(CYCLE_MAX), 2, 0);
        send_beat(KIND_START, 4'h7, 1'b0);
        // shorter period mid-burst lets the cycle counter run into its limit
        load_config(32'(CYCLE_MAX), 1, 0);
        repeat (260)
            send_beat(KIND_TICK, 4'h0, 1'($urandom_range(1)));
        send_beat(KIND_STOP, 4'h0, 1'b0);
    endtask

    task automatic test_random_bursts();
        int runs_left;
        for (int p = 0; p < 4; p++) begin
            idle_pct  = (p == 1) ? 47 : (p == 3) ? 28 : 0;
            stall_pct = (p == 2) ? 47 : (p == 3) ? 28 : 0;
            runs_left = 0;
            for (int n = 0; n < 90; n++) begin
                if (runs_left == 0) begin
                    load_config(pick_count(), pick_time(), pick_time());
                    runs_left = $urandom_range(12, 35);
                end
                runs_left--;
                send_item(pick_beat());
            end
        end
    endtask

    initial begin
        reset_mirror();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_kinds();
        test_field_extremes();
        test_short_burst();
        test_zero_totals();
        test_cycle_saturation();
        test_random_bursts();
        wait_drained();
        $display("sent %0d item beats under four idle/stall mixes, checked %0d result beats",
                 items_sent, reports_checked);
        $display("%0d bursts finished, highest cycle number %0d, %0d mismatches",
                 finishes_seen, max_cycle_seen, errors);
        if (errors == 0 && burst_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
